### design/line_sensor_peak_finder_unit_defines.svh
`ifndef LINE_SENSOR_PEAK_FINDER_UNIT_DEFINES_SVH
`define LINE_SENSOR_PEAK_FINDER_UNIT_DEFINES_SVH

// same-cycle implication
`define LSPF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lspf check failed");

// next-cycle implication
`define LSPF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lspf check failed");

`endif

### design/lspf_pkg.sv
package lspf_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int POSITION_W = 5;
  localparam int MARGIN_W   = 12;
  localparam int RADIUS_W   = 5;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [POSITION_W-1:0] position_t;
  typedef logic [MARGIN_W-1:0]   margin_t;
  typedef logic [RADIUS_W-1:0]   radius_t;
  typedef logic [1:0]            reg_index_t;

  localparam reg_index_t REG_GLOBAL_MARGIN   = 2'd0;
  localparam reg_index_t REG_SALIENCE_RADIUS = 2'd1;
  localparam reg_index_t REG_SALIENCE_MARGIN = 2'd2;

  localparam margin_t GLOBAL_MARGIN_RST   = 12'd1000;
  localparam radius_t SALIENCE_RADIUS_RST = 5'd2;
  localparam margin_t SALIENCE_MARGIN_RST = 12'd200;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MARK,
    CELL_WIDEN,
    CELL_JUDGE,
    CELL_SCAN
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MARK,
    ST_WIDEN,
    ST_JUDGE,
    ST_SCAN,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    cell_op_t op;
    sample_t  frame_max;
    margin_t  global_margin;
    margin_t  salience_margin;
  } cell_ctrl_t;

  typedef struct packed {
    sample_t sample;
    logic    cand;
    logic    sal;
  } head_t;

endpackage

### design/lspf_if.sv
interface lspf_sample_if;
  import lspf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sensor_sample;
  modport source (output valid, output sensor_sample, input ready);
  modport sink (input valid, input sensor_sample, output ready);
endinterface

interface lspf_peak_if;
  import lspf_pkg::*;
  logic      valid;
  logic      ready;
  logic      peak_found;
  position_t peak_position;
  sample_t   peak_level;
  logic      last_peak;
  modport source (output valid, output peak_found, output peak_position,
                  output peak_level, output last_peak, input ready);
  modport sink (input valid, input peak_found, input peak_position,
                input peak_level, input last_peak, output ready);
endinterface

### design/lspf_cell.sv
module lspf_cell #(
  parameter bit HAS_LEFT  = 1'b1,
  parameter bit HAS_RIGHT = 1'b1
) (
  input  logic                clk,
  input  lspf_pkg::cell_ctrl_t ctrl,
  input  lspf_pkg::sample_t   left_sample,
  input  lspf_pkg::sample_t   left_lmin,
  input  lspf_pkg::sample_t   right_sample,
  input  lspf_pkg::sample_t   right_rmin,
  input  logic                right_cand,
  input  logic                right_sal,
  output lspf_pkg::sample_t   sample,
  output lspf_pkg::sample_t   lmin,
  output lspf_pkg::sample_t   rmin,
  output logic                cand,
  output logic                sal
);
  import lspf_pkg::*;

  logic    left_ok;
  logic    right_ok;
  logic    above_floor;
  sample_t window_min;
  logic    salient;

  always_comb begin
    left_ok     = !HAS_LEFT || (sample > left_sample);
    right_ok    = !HAS_RIGHT || (sample > right_sample);
    above_floor = (ctrl.frame_max <= ctrl.global_margin) ||
                  (sample > (ctrl.frame_max - ctrl.global_margin));
    window_min  = (lmin < rmin) ? lmin : rmin;
    salient     = {1'b0, sample} > ({1'b0, window_min} + {1'b0, ctrl.salience_margin});
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        sample <= right_sample;
      end
      CELL_MARK: begin
        cand <= left_ok && right_ok && above_floor;
        lmin <= sample;
        rmin <= sample;
      end
      CELL_WIDEN: begin
        if (HAS_LEFT && (left_lmin < lmin)) begin
          lmin <= left_lmin;
        end
        if (HAS_RIGHT && (right_rmin < rmin)) begin
          rmin <= right_rmin;
        end
      end
      CELL_JUDGE: begin
        sal <= salient;
      end
      CELL_SCAN: begin
        sample <= right_sample;
        cand   <= right_cand;
        sal    <= right_sal;
      end
    endcase
  end

endmodule

### design/lspf_seq.sv
module lspf_seq #(
  parameter int NUM_SENSORS = 32,
  parameter int MAX_PEAKS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  lspf_sample_if.sink          samples,
  lspf_peak_if.source          peaks,
  input  lspf_pkg::margin_t    global_margin,
  input  lspf_pkg::radius_t    salience_radius,
  input  lspf_pkg::margin_t    salience_margin,
  input  lspf_pkg::head_t      head,
  output lspf_pkg::cell_ctrl_t cell_ctrl
);
  import lspf_pkg::*;

  localparam int CNT_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int KEPT_W = $clog2(MAX_PEAKS + 1);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_pos;
  logic [KEPT_W-1:0] kept;
  radius_t           step;
  sample_t           frame_max;
  logic              pend_valid;
  logic [CNT_W-1:0]  pend_pos;
  sample_t           pend_level;
  logic              out_valid;
  logic              out_found;
  position_t         out_pos;
  sample_t           out_level;
  logic              out_last;

  logic in_accept;
  logic last_sample;
  logic scan_last;
  logic out_free;
  logic take;
  logic emit;
  logic stall;
  logic out_load;

  always_comb begin
    in_accept   = samples.valid && (state == ST_LOAD);
    last_sample = (count == CNT_W'(NUM_SENSORS - 1));
    scan_last   = (scan_pos == CNT_W'(NUM_SENSORS - 1));
    out_free    = !out_valid || peaks.ready;
    take        = head.cand && (kept < KEPT_W'(MAX_PEAKS));
    emit        = take && head.sal;
    stall       = emit && pend_valid && !out_free;
    out_load    = ((state == ST_SCAN) && !stall && emit && pend_valid) ||
                  ((state == ST_FLUSH) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_accept && last_sample) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        state_next = (salience_radius == '0) ? ST_JUDGE : ST_WIDEN;
      end
      ST_WIDEN: begin
        if (step == (salience_radius - 1'b1)) begin
          state_next = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall && scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
    endcase
  end

  always_comb begin
    samples.ready             = (state == ST_LOAD);
    cell_ctrl.frame_max       = frame_max;
    cell_ctrl.global_margin   = global_margin;
    cell_ctrl.salience_margin = salience_margin;
    unique case (state)
      ST_LOAD:  cell_ctrl.op = in_accept ? CELL_LOAD : CELL_HOLD;
      ST_MARK:  cell_ctrl.op = CELL_MARK;
      ST_WIDEN: cell_ctrl.op = CELL_WIDEN;
      ST_JUDGE: cell_ctrl.op = CELL_JUDGE;
      ST_SCAN:  cell_ctrl.op = stall ? CELL_HOLD : CELL_SCAN;
      ST_FLUSH: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      scan_pos   <= '0;
      kept       <= '0;
      step       <= '0;
      frame_max  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && peaks.ready) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        count <= last_sample ? '0 : count + 1'b1;
        if (samples.sensor_sample > frame_max) begin
          frame_max <= samples.sensor_sample;
        end
      end
      if (state == ST_MARK) begin
        frame_max <= '0;
        step      <= '0;
      end
      if (state == ST_WIDEN) begin
        step <= step + 1'b1;
      end
      if (state == ST_JUDGE) begin
        scan_pos   <= '0;
        kept       <= '0;
        pend_valid <= 1'b0;
      end
      if ((state == ST_SCAN) && !stall) begin
        scan_pos <= scan_pos + 1'b1;
        if (take) begin
          kept <= kept + 1'b1;
        end
        if (emit) begin
          pend_pos   <= scan_pos;
          pend_level <= head.sample;
          pend_valid <= 1'b1;
          if (pend_valid) begin
            out_found <= 1'b1;
            out_pos   <= POSITION_W'(pend_pos);
            out_level <= pend_level;
            out_last  <= 1'b0;
          end
        end
      end
      if ((state == ST_FLUSH) && out_free) begin
        out_found <= pend_valid;
        out_pos   <= pend_valid ? POSITION_W'(pend_pos) : '0;
        out_level <= pend_valid ? pend_level : '0;
        out_last  <= 1'b1;
      end
    end
  end

  assign peaks.valid         = out_valid;
  assign peaks.peak_found    = out_found;
  assign peaks.peak_position = out_pos;
  assign peaks.peak_level    = out_level;
  assign peaks.last_peak     = out_last;

endmodule

### design/line_sensor_peak_finder_unit.sv
// one request per cycle while a frame loads
// evaluation: mark, widen (at nonzero radius) and judge steps in the cell row, then the
// output scan of every sensor and a closing flush, held only while the result sink stalls
// first result registered once the scan reaches the second salient peak, or in the
// closing flush when there is no second salient peak
// synchronous reset restarts frame loading, clears the result valid, loads default config
module line_sensor_peak_finder_unit #(
  parameter int NUM_SENSORS = 32,
  parameter int MAX_PEAKS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  lspf_sample_if.sink                          samples,
  lspf_peak_if.source                          peaks,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lspf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lspf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lspf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import lspf_pkg::*;

  margin_t    global_margin;
  radius_t    salience_radius;
  margin_t    salience_margin;
  reg_index_t reg_index;
  logic       apb_write;

  cell_ctrl_t cell_ctrl;
  head_t      head;

  sample_t row_sample [NUM_SENSORS];
  sample_t row_lmin   [NUM_SENSORS];
  sample_t row_rmin   [NUM_SENSORS];
  logic    row_cand   [NUM_SENSORS];
  logic    row_sal    [NUM_SENSORS];

  sample_t nb_left_sample  [NUM_SENSORS];
  sample_t nb_left_lmin    [NUM_SENSORS];
  sample_t nb_right_sample [NUM_SENSORS];
  sample_t nb_right_rmin   [NUM_SENSORS];
  logic    nb_right_cand   [NUM_SENSORS];
  logic    nb_right_sal    [NUM_SENSORS];

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign apb_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_margin   <= GLOBAL_MARGIN_RST;
      salience_radius <= SALIENCE_RADIUS_RST;
      salience_margin <= SALIENCE_MARGIN_RST;
    end else if (apb_write) begin
      unique case (reg_index)
        REG_GLOBAL_MARGIN:   global_margin   <= pwdata[MARGIN_W-1:0];
        REG_SALIENCE_RADIUS: salience_radius <= pwdata[RADIUS_W-1:0];
        REG_SALIENCE_MARGIN: salience_margin <= pwdata[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_GLOBAL_MARGIN:   prdata = APB_DATA_W'(global_margin);
      REG_SALIENCE_RADIUS: prdata = APB_DATA_W'(salience_radius);
      REG_SALIENCE_MARGIN: prdata = APB_DATA_W'(salience_margin);
      default:             prdata = '0;
    endcase
  end

  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_row
    if (i == 0) begin : g_left_edge
      assign nb_left_sample[i] = '0;
      assign nb_left_lmin[i]   = '0;
    end else begin : g_left_inner
      assign nb_left_sample[i] = row_sample[i-1];
      assign nb_left_lmin[i]   = row_lmin[i-1];
    end

    if (i == NUM_SENSORS - 1) begin : g_right_edge
      assign nb_right_sample[i] = samples.sensor_sample;
      assign nb_right_rmin[i]   = '0;
      assign nb_right_cand[i]   = 1'b0;
      assign nb_right_sal[i]    = 1'b0;
    end else begin : g_right_inner
      assign nb_right_sample[i] = row_sample[i+1];
      assign nb_right_rmin[i]   = row_rmin[i+1];
      assign nb_right_cand[i]   = row_cand[i+1];
      assign nb_right_sal[i]    = row_sal[i+1];
    end

    lspf_cell #(
      .HAS_LEFT  (i != 0),
      .HAS_RIGHT (i != NUM_SENSORS - 1)
    ) u_cell (
      .clk          (clk),
      .ctrl         (cell_ctrl),
      .left_sample  (nb_left_sample[i]),
      .left_lmin    (nb_left_lmin[i]),
      .right_sample (nb_right_sample[i]),
      .right_rmin   (nb_right_rmin[i]),
      .right_cand   (nb_right_cand[i]),
      .right_sal    (nb_right_sal[i]),
      .sample       (row_sample[i]),
      .lmin         (row_lmin[i]),
      .rmin         (row_rmin[i]),
      .cand         (row_cand[i]),
      .sal          (row_sal[i])
    );
  end

  assign head.sample = row_sample[0];
  assign head.cand   = row_cand[0];
  assign head.sal    = row_sal[0];

  lspf_seq #(
    .NUM_SENSORS (NUM_SENSORS),
    .MAX_PEAKS   (MAX_PEAKS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .samples         (samples),
    .peaks           (peaks),
    .global_margin   (global_margin),
    .salience_radius (salience_radius),
    .salience_margin (salience_margin),
    .head            (head),
    .cell_ctrl       (cell_ctrl)
  );

endmodule

### design/lspf_checker.sv
`include "line_sensor_peak_finder_unit_defines.svh"

module lspf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                peak_found,
  input lspf_pkg::position_t peak_position,
  input lspf_pkg::sample_t   peak_level,
  input logic                last_peak
);
  import lspf_pkg::*;

  // a stalled result holds
  `LSPF_ASSERT_NXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(peak_found) && $stable(peak_position) && $stable(peak_level) && $stable(last_peak))

  // empty frame gives a single zeroed closing result
  `LSPF_ASSERT_IMP(a_empty_closes, clk, rst, out_valid && !peak_found, last_peak && (peak_position == '0) && (peak_level == '0))

  // a salient peak sits above some sample within its radius, so its level is never zero
  `LSPF_ASSERT_IMP(a_peak_level_set, clk, rst, out_valid && peak_found, peak_level != '0)

  // no new frame is taken while the current one still has results to come
  `LSPF_ASSERT_IMP(a_frame_not_done, clk, rst, out_valid && !last_peak, !in_ready)

endmodule

bind line_sensor_peak_finder_unit lspf_checker u_lspf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (samples.ready),
  .out_valid     (peaks.valid),
  .out_ready     (peaks.ready),
  .peak_found    (peaks.peak_found),
  .peak_position (peaks.peak_position),
  .peak_level    (peaks.peak_level),
  .last_peak     (peaks.last_peak)
);

### sim/line_sensor_peak_finder_unit_tb.sv
module line_sensor_peak_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lspf_pkg::*;

  localparam int NUM_SENSORS = 32;
  localparam int MAX_PEAKS   = 16;
  localparam int SETTLE      = 80;
  localparam int HOLD_OFF    = 400;
  localparam int LIMIT       = 200000;

  typedef struct packed {
    logic      found;
    position_t position;
    sample_t   level;
    logic      last;
  } peak_t;

  class frame_peak_board;
    margin_t   global_margin;
    radius_t   salience_radius;
    margin_t   salience_margin;
    sample_t   frame[NUM_SENSORS];
    int        filled;
    sample_t   frame_max;
    peak_t     expected_peaks[$];
    int        errors;
    int        peaks_checked;
    int        frames_seen;
    int        samples_seen;

    function new();
      global_margin   = GLOBAL_MARGIN_RST;
      salience_radius = SALIENCE_RADIUS_RST;
      salience_margin = SALIENCE_MARGIN_RST;
      filled          = 0;
      frame_max       = '0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_GLOBAL_MARGIN:   global_margin   = value[MARGIN_W-1:0];
        REG_SALIENCE_RADIUS: salience_radius = value[RADIUS_W-1:0];
        REG_SALIENCE_MARGIN: salience_margin = value[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_salient(int p);
      int lo;
      int hi;
      lo = p - int'(salience_radius);
      hi = p + int'(salience_radius);
      for (int j = lo; j <= hi; j++) begin
        if (j < 0 || j >= NUM_SENSORS) continue;
        if (int'(frame[p]) > int'(frame[j]) + int'(salience_margin)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void find_peaks();
      int    picked[$];
      bit    left_ok;
      bit    right_ok;
      peak_t res;
      int    n;
      for (int p = 0; p < NUM_SENSORS && picked.size() < MAX_PEAKS; p++) begin
        left_ok  = (p == 0) || (frame[p] > frame[p-1]);
        right_ok = (p == NUM_SENSORS - 1) || (frame[p] > frame[p+1]);
        if (!(left_ok && right_ok)) continue;
        if (int'(frame_max) > int'(global_margin) &&
            !(int'(frame[p]) > int'(frame_max) - int'(global_margin))) continue;
        picked.push_back(p);
      end
      n = 0;
      foreach (picked[k]) begin
        if (!is_salient(picked[k])) continue;
        res.found    = 1'b1;
        res.position = position_t'(picked[k]);
        res.level    = frame[picked[k]];
        res.last     = 1'b0;
        expected_peaks.push_back(res);
        n++;
      end
      if (n == 0) begin
        res = '0;
        res.last = 1'b1;
        expected_peaks.push_back(res);
      end else begin
        expected_peaks[expected_peaks.size()-1].last = 1'b1;
      end
      frames_seen++;
    endfunction

    function void take_sample(sample_t s);
      frame[filled] = s;
      if (s > frame_max) frame_max = s;
      filled++;
      samples_seen++;
      if (filled == NUM_SENSORS) begin
        find_peaks();
        filled    = 0;
        frame_max = '0;
      end
    endfunction

    function void match_peak(peak_t got);
      peak_t want;
      if (expected_peaks.size() == 0) begin
        $error("unexpected peak result: found %0d position %0d level %0d last %0d",
               got.found, got.position, got.level, got.last);
        errors++;
        return;
      end
      want = expected_peaks.pop_front();
      peaks_checked++;
      if (got.found !== want.found) begin
        $error("peak_found: expected %0d actual %0d", want.found, got.found);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("peak_position: expected %0d actual %0d", want.position, got.position);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("peak_level: expected %0d actual %0d", want.level, got.level);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_peak: expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lspf_sample_if sample_bus();
  lspf_peak_if   peak_bus();

  frame_peak_board board;
  bit              calm;
  bit              hold_req;
  int              cycles;
  int              settings;

  line_sensor_peak_finder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .peaks   (peak_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    peak_t got;
    if (!rst && peak_bus.valid && peak_bus.ready) begin
      got.found    = peak_bus.peak_found;
      got.position = peak_bus.peak_position;
      got.level    = peak_bus.peak_level;
      got.last     = peak_bus.last_peak;
      board.match_peak(got);
    end
  end

  // result sink, with one long hold-off on request
  initial begin
    int held;
    peak_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        peak_bus.ready = 1'b0;
        held = 0;
        while (held < HOLD_OFF) begin
          @(negedge clk);
          held++;
        end
        hold_req = 1'b0;
      end
      peak_bus.ready = calm ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  task automatic apb_write(reg_index_t idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(reg_index_t idx, logic [31:0] want, string name);
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      $error("%s: expected %0d actual %0d", name, want, got);
      board.errors++;
    end
  endtask

  task automatic program_setting(int gm, int radius, int sm);
    int junk;
    junk = $urandom & 32'hFFFF_F000;
    apb_write(REG_GLOBAL_MARGIN, junk | gm);
    board.set_reg(REG_GLOBAL_MARGIN, junk | gm);
    junk = $urandom & 32'hFFFF_FFE0;
    apb_write(REG_SALIENCE_RADIUS, junk | radius);
    board.set_reg(REG_SALIENCE_RADIUS, junk | radius);
    junk = $urandom & 32'hFFFF_F000;
    apb_write(REG_SALIENCE_MARGIN, junk | sm);
    board.set_reg(REG_SALIENCE_MARGIN, junk | sm);
    apb_check(REG_GLOBAL_MARGIN, gm, "global_margin");
    apb_check(REG_SALIENCE_RADIUS, radius, "salience_radius");
    apb_check(REG_SALIENCE_MARGIN, sm, "salience_margin");
    settings++;
  endtask

  task automatic send_sample(sample_t s);
    while (!calm && $urandom_range(99) < 11) begin
      sample_bus.valid = 1'b0;
      @(negedge clk);
    end
    sample_bus.valid         = 1'b1;
    sample_bus.sensor_sample = s;
    do @(posedge clk); while (!sample_bus.ready);
    board.take_sample(s);
    @(negedge clk);
  endtask

  task automatic send_frame(sample_t f[NUM_SENSORS]);
    for (int i = 0; i < NUM_SENSORS; i++) send_sample(f[i]);
  endtask

  task automatic wait_idle();
    sample_bus.valid = 1'b0;
    while (board.expected_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly bumps on a noisy floor, some raw noise, some plateaus from few levels
  task automatic random_frame(output sample_t f[NUM_SENSORS]);
    int kind;
    int floor_lvl;
    int bumps;
    int centre;
    int height;
    int width;
    int v;
    sample_t levels[3];
    kind = $urandom_range(9);
    if (kind < 6) begin
      floor_lvl = $urandom_range(1500);
      for (int i = 0; i < NUM_SENSORS; i++) f[i] = sample_t'(floor_lvl + $urandom_range(63));
      bumps = $urandom_range(1, 6);
      for (int b = 0; b < bumps; b++) begin
        centre = $urandom_range(NUM_SENSORS - 1);
        height = $urandom_range(4095);
        width  = $urandom_range(1, 4);
        for (int d = -width; d <= width; d++) begin
          if (centre + d < 0 || centre + d >= NUM_SENSORS) continue;
          v = height - (height / (width + 1)) * (d < 0 ? -d : d);
          if (v > int'(f[centre+d])) f[centre+d] = sample_t'(v);
        end
      end
    end else if (kind < 8) begin
      for (int i = 0; i < NUM_SENSORS; i++) f[i] = sample_t'($urandom);
    end else begin
      levels[0] = '0;
      levels[1] = '1;
      levels[2] = sample_t'($urandom);
      for (int i = 0; i < NUM_SENSORS; i++) f[i] = levels[$urandom_range(2)];
    end
  endtask

  task automatic random_phase(int frames);
    sample_t f[NUM_SENSORS];
    for (int k = 0; k < frames; k++) begin
      random_frame(f);
      send_frame(f);
    end
    wait_idle();
  endtask

  initial begin
    sample_t f[NUM_SENSORS];
    board                    = new();
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    sample_bus.valid         = 1'b0;
    sample_bus.sensor_sample = '0;
    calm                     = 1'b0;
    hold_req                 = 1'b0;
    cycles                   = 0;
    settings                 = 1;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    apb_check(REG_GLOBAL_MARGIN, GLOBAL_MARGIN_RST, "global_margin");
    apb_check(REG_SALIENCE_RADIUS, SALIENCE_RADIUS_RST, "salience_radius");
    apb_check(REG_SALIENCE_MARGIN, SALIENCE_MARGIN_RST, "salience_margin");

    // alternating extremes: the most local maxima a frame can hold
    for (int i = 0; i < NUM_SENSORS; i++) f[i] = (i % 2) ? '1 : '0;
    send_frame(f);
    // v shape: peaks only on the first and the last sensor
    for (int i = 0; i < NUM_SENSORS; i++)
      f[i] = sample_t'(4095 - 120 * ((i < 16) ? i : (NUM_SENSORS - 1 - i)) - (i / 16));
    send_frame(f);
    // all zero and all full scale: no strict maximum, empty frame
    for (int i = 0; i < NUM_SENSORS; i++) f[i] = '0;
    send_frame(f);
    for (int i = 0; i < NUM_SENSORS; i++) f[i] = '1;
    send_frame(f);
    wait_idle();

    program_setting(4095, 31, 0);
    hold_req = 1'b1;
    random_phase(2);
    program_setting(0, 0, 4095);
    random_phase(1);
    calm = 1'b1;
    program_setting(800, 3, 150);
    random_phase(2);
    calm = 1'b0;
    program_setting($urandom_range(4095), $urandom_range(31), $urandom_range(4095));
    random_phase(1);
    program_setting(3000, 1, 40);
    random_phase(1);
    program_setting($urandom_range(1500, 4095), $urandom_range(1, 8), $urandom_range(600));
    random_phase(1);
    program_setting(GLOBAL_MARGIN_RST, SALIENCE_RADIUS_RST, SALIENCE_MARGIN_RST);
    random_phase(1);

    if (board.expected_peaks.size() != 0) begin
      $error("%0d expected peak results never arrived", board.expected_peaks.size());
      board.errors++;
    end
    $display("%0d frames (%0d samples) under %0d register settings, %0d peak results checked",
             board.frames_seen, board.samples_seen, settings, board.peaks_checked);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lspf_pkg.sv
design/lspf_if.sv
design/lspf_cell.sv
design/lspf_seq.sv
design/line_sensor_peak_finder_unit.sv
design/lspf_checker.sv
sim/line_sensor_peak_finder_unit_tb.sv
